/* hdl/irt_pkg.sv */
// shared types, constants and helpers for the interrupt route table
package irt_pkg;

  localparam int OVERRIDE_SLOTS_DEF = 16;
  localparam int REDIR_ENTRIES_DEF  = 24;

  localparam int MASK_POS    = 16;
  localparam int LEVEL_POS   = 15;
  localparam int LOWACT_POS  = 13;
  localparam logic [1:0] FLAG_SET = 2'b11;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_DISABLED = 3'd1;
  localparam logic [2:0] STAT_BELOW    = 3'd2;
  localparam logic [2:0] STAT_BEYOND   = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  localparam logic [1:0] REG_FIRST_GSI   = 2'd0;
  localparam logic [1:0] REG_REDIR_COUNT = 2'd1;
  localparam logic [1:0] REG_ENABLED     = 2'd2;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_ROUTE  = 2'd1,
    FN_MASK   = 2'd2,
    FN_UNMASK = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CHECK,
    S_RD,
    S_WR
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  irq;
    logic [7:0]  vector;
    logic [7:0]  apic_id;
    logic [31:0] ovr_gsi;
    logic [3:0]  ovr_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_index;
    logic [31:0] entry_low;
    logic [7:0]  entry_dest;
  } rsp_t;

  typedef struct packed {
    logic [31:0] first_gsi;
    logic [4:0]  redir_count;
    logic        enabled;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic add;
    logic scan_inc;
    logic scan_hit;
    logic scan_miss;
    logic fail;
    logic sel;
    logic rd;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       match;
    logic       scan_end;
    logic       resolve_ok;
  } sts_t;

  typedef struct packed {
    logic       mask;
    logic       level;
    logic       lowact;
    logic [7:0] vector;
    logic [7:0] dest;
  } redir_t;

  function automatic logic [31:0] make_low(input redir_t e);
    logic [31:0] w;
    w             = '0;
    w[7:0]        = e.vector;
    w[LOWACT_POS] = e.lowact;
    w[LEVEL_POS]  = e.level;
    w[MASK_POS]   = e.mask;
    return w;
  endfunction

endpackage

/* hdl/interrupt_route_table_top.sv */
// top level of the interrupt route table
//
//   channel   signals                               direction
//   item      start, busy, req                      in, busy back
//   result    done, rsp                             out, one cycle strobe
//   config    psel penable pwrite paddr pwdata      in, prdata/pready out
//
// add override: the result strobe is registered from the decode state
// route, mask, unmask: decode, a walk over the override slots up to the first
// match or the fill count (at most 16), one compare per cycle, then the check
// a refused route, mask or unmask answers from the check state
// the redirection entry costs one registered read and one write
// rst is synchronous; the table reads as masked until first written
// results cannot be stalled; start is taken whenever busy is low
module interrupt_route_table_top #(
  parameter int OVERRIDE_SLOTS = irt_pkg::OVERRIDE_SLOTS_DEF,
  parameter int REDIR_ENTRIES  = irt_pkg::REDIR_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  irt_pkg::req_t req,
  output logic          done,
  output irt_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  irt_pkg::cfg_t cfg;
  irt_pkg::cmd_t cmd;
  irt_pkg::sts_t sts;

  irt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  irt_dp #(
    .OVERRIDE_SLOTS (OVERRIDE_SLOTS),
    .REDIR_ENTRIES  (REDIR_ENTRIES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cfg  (cfg),
    .cmd  (cmd),
    .sts  (sts),
    .rsp  (rsp),
    .done (done)
  );

endmodule

/* hdl/irt_regs.sv */
// configuration registers behind the apb port
module irt_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output irt_pkg::cfg_t     cfg
);

  irt_pkg::cfg_t regs;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_gsi   <= '0;
      regs.redir_count <= 5'd24;
      regs.enabled     <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        irt_pkg::REG_FIRST_GSI:   regs.first_gsi   <= pwdata;
        irt_pkg::REG_REDIR_COUNT: regs.redir_count <= pwdata[4:0];
        irt_pkg::REG_ENABLED:     regs.enabled     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      irt_pkg::REG_FIRST_GSI:   prdata = regs.first_gsi;
      irt_pkg::REG_REDIR_COUNT: prdata = {27'b0, regs.redir_count};
      irt_pkg::REG_ENABLED:     prdata = {31'b0, regs.enabled};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* hdl/irt_ctrl.sv */
// sequencing state machine for override add, lookup, check and read-modify-write
module irt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  irt_pkg::sts_t sts,
  output irt_pkg::cmd_t cmd
);

  irt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != irt_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      irt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = irt_pkg::S_DECODE;
        end
      end
      irt_pkg::S_DECODE: begin
        if (sts.func == irt_pkg::FN_ADD) begin
          cmd.add    = 1'b1;
          state_next = irt_pkg::S_IDLE;
        end else begin
          state_next = irt_pkg::S_SCAN;
        end
      end
      irt_pkg::S_SCAN: begin
        priority if (sts.match) begin
          cmd.scan_hit = 1'b1;
          state_next   = irt_pkg::S_CHECK;
        end else if (sts.scan_end) begin
          cmd.scan_miss = 1'b1;
          state_next    = irt_pkg::S_CHECK;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      irt_pkg::S_CHECK: begin
        if (sts.resolve_ok) begin
          cmd.sel    = 1'b1;
          state_next = irt_pkg::S_RD;
        end else begin
          cmd.fail   = 1'b1;
          state_next = irt_pkg::S_IDLE;
        end
      end
      irt_pkg::S_RD: begin
        cmd.rd     = 1'b1;
        state_next = irt_pkg::S_WR;
      end
      irt_pkg::S_WR: begin
        cmd.wr     = 1'b1;
        state_next = irt_pkg::S_IDLE;
      end
      default: state_next = irt_pkg::S_IDLE;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add, cmd.fail, cmd.wr}))
    else $error("more than one result issued");

  a_wr_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> !busy)
    else $error("write-back did not end the item");

endmodule

/* hdl/irt_dp.sv */
// override table, redirection table and item datapath
module irt_dp #(
  parameter int OVERRIDE_SLOTS = irt_pkg::OVERRIDE_SLOTS_DEF,
  parameter int REDIR_ENTRIES  = irt_pkg::REDIR_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  irt_pkg::req_t req,
  input  irt_pkg::cfg_t cfg,
  input  irt_pkg::cmd_t cmd,
  output irt_pkg::sts_t sts,
  output irt_pkg::rsp_t rsp,
  output logic          done
);

  localparam int CNT_W  = $clog2(OVERRIDE_SLOTS + 1);
  localparam int SLOT_W = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
  localparam int IDX_W  = (REDIR_ENTRIES > 1) ? $clog2(REDIR_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(OVERRIDE_SLOTS);

  logic [7:0]  ovr_src  [OVERRIDE_SLOTS];
  logic [31:0] ovr_tgt  [OVERRIDE_SLOTS];
  logic [3:0]  ovr_mode [OVERRIDE_SLOTS];
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] cnt;

  irt_pkg::redir_t redir_mem [REDIR_ENTRIES];
  logic [REDIR_ENTRIES-1:0] redir_vld;

  irt_pkg::req_t   item;
  logic [31:0]     gsi;
  logic [3:0]      mode;
  logic            hit;
  logic [IDX_W-1:0] addr;
  logic [4:0]      eidx;
  irt_pkg::redir_t rd_ent;
  logic            rd_vld;

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] add_slot;
  logic              in_use;
  logic              full;
  logic [31:0]       lim;
  logic [31:0]       diff;
  logic [2:0]        code;
  irt_pkg::redir_t   cur;
  irt_pkg::redir_t   upd;

  assign slot     = cnt[SLOT_W-1:0];
  assign add_slot = used[SLOT_W-1:0];
  assign in_use   = (cnt < used);
  assign full     = (used >= SLOTS_FULL);

  assign sts.func       = item.func;
  assign sts.match      = in_use && (ovr_src[slot] == item.irq);
  assign sts.scan_end   = !in_use;
  assign sts.resolve_ok = (code == irt_pkg::STAT_OK);

  always_comb begin
    lim  = ({27'b0, cfg.redir_count} < 32'(REDIR_ENTRIES)) ?
           {27'b0, cfg.redir_count} : 32'(REDIR_ENTRIES);
    diff = gsi - cfg.first_gsi;
    priority if (!cfg.enabled) begin
      code = irt_pkg::STAT_DISABLED;
    end else if (gsi < cfg.first_gsi) begin
      code = irt_pkg::STAT_BELOW;
    end else if (diff >= lim) begin
      code = irt_pkg::STAT_BEYOND;
    end else begin
      code = irt_pkg::STAT_OK;
    end
  end

  always_comb begin
    if (rd_vld) begin
      cur = rd_ent;
    end else begin
      cur      = '0;
      cur.mask = 1'b1;
    end
    upd = cur;
    unique case (irt_pkg::func_t'(item.func))
      irt_pkg::FN_ROUTE: begin
        upd.mask   = 1'b0;
        upd.vector = item.vector;
        upd.dest   = item.apic_id;
        upd.lowact = hit && (mode[1:0] == irt_pkg::FLAG_SET);
        upd.level  = hit && (mode[3:2] == irt_pkg::FLAG_SET);
      end
      irt_pkg::FN_MASK:   upd.mask = 1'b1;
      irt_pkg::FN_UNMASK: upd.mask = 1'b0;
      irt_pkg::FN_ADD:    upd = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.scan_hit) begin
      gsi  <= ovr_tgt[slot];
      mode <= ovr_mode[slot];
      hit  <= 1'b1;
    end
    if (cmd.scan_miss) begin
      gsi  <= {24'b0, item.irq};
      mode <= '0;
      hit  <= 1'b0;
    end
    if (cmd.sel) begin
      addr <= diff[IDX_W-1:0];
      eidx <= diff[4:0];
    end
    if (cmd.add && !full) begin
      ovr_src[add_slot]  <= item.irq;
      ovr_tgt[add_slot]  <= item.ovr_gsi;
      ovr_mode[add_slot] <= item.ovr_flags;
    end
    if (cmd.add) begin
      rsp <= '{status: (full ? irt_pkg::STAT_FULL : irt_pkg::STAT_OK),
               entry_index: '0, entry_low: '0, entry_dest: '0};
    end
    if (cmd.fail) begin
      rsp <= '{status: code, entry_index: '0, entry_low: '0, entry_dest: '0};
    end
    if (cmd.wr) begin
      rsp.status      <= irt_pkg::STAT_OK;
      rsp.entry_index <= eidx;
      rsp.entry_low   <= irt_pkg::make_low(upd);
      rsp.entry_dest  <= upd.dest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.add | cmd.fail | cmd.wr;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.scan_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.add && !full) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_ent <= redir_mem[addr];
    end
    if (cmd.wr) begin
      redir_mem[addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      redir_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_vld <= redir_vld[addr];
      end
      if (cmd.wr) begin
        redir_vld[addr] <= 1'b1;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= SLOTS_FULL)
    else $error("override count beyond slots");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.add && !full) |=> (used == $past(used) + 1'b1))
    else $error("override add did not advance count");

endmodule

/* dv/interrupt_route_table_top_tb.sv */
// testbench for the interrupt route table: directed and random items checked by a built-in model
`timescale 1ns / 100ps

module interrupt_route_table_top_tb;

  localparam int SLOTS        = 16;
  localparam int ENTRIES      = 24;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 6;

  class route_scoreboard;
    logic [31:0] first_gsi;
    logic [4:0]  redir_count;
    logic        enabled;
    logic [7:0]  ovr_src [SLOTS];
    logic [31:0] ovr_tgt [SLOTS];
    logic [3:0]  ovr_mode [SLOTS];
    int          ovr_used;
    logic [31:0] redir_low [ENTRIES];
    logic [7:0]  redir_dest [ENTRIES];
    irt_pkg::rsp_t expected_rsp [$];
    int          errors;
    int          items;
    int          results;
    int          status_seen [5];

    function new();
      first_gsi   = '0;
      redir_count = 5'd24;
      enabled     = 1'b0;
      ovr_used    = 0;
      errors      = 0;
      items       = 0;
      results     = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        redir_low[i]  = 32'h0001_0000;
        redir_dest[i] = '0;
      end
      for (int i = 0; i < 5; i++) status_seen[i] = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
        irt_pkg::REG_FIRST_GSI:   first_gsi = v;
        irt_pkg::REG_REDIR_COUNT: redir_count = v[4:0];
        irt_pkg::REG_ENABLED:     enabled = v[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(input logic [1:0] idx);
      case (idx)
        irt_pkg::REG_FIRST_GSI:   return first_gsi;
        irt_pkg::REG_REDIR_COUNT: return {27'd0, redir_count};
        default:                  return {31'd0, enabled};
      endcase
    endfunction

    function void note_request(input irt_pkg::req_t r);
      irt_pkg::rsp_t e;
      int          hit;
      int          lim;
      logic [31:0] gsi;
      logic [31:0] idx;
      logic [31:0] low;
      e   = '0;
      hit = -1;
      if (r.func == irt_pkg::FN_ADD) begin
        if (ovr_used >= SLOTS) begin
          e.status = irt_pkg::STAT_FULL;
        end else begin
          ovr_src[ovr_used]  = r.irq;
          ovr_tgt[ovr_used]  = r.ovr_gsi;
          ovr_mode[ovr_used] = r.ovr_flags;
          ovr_used++;
          e.status = irt_pkg::STAT_OK;
        end
      end else if (!enabled) begin
        e.status = irt_pkg::STAT_DISABLED;
      end else begin
        for (int i = ovr_used - 1; i >= 0; i--)
          if (ovr_src[i] == r.irq) hit = i;
        gsi = (hit >= 0) ? ovr_tgt[hit] : {24'd0, r.irq};
        lim = (redir_count < ENTRIES) ? int'(redir_count) : ENTRIES;
        idx = gsi - first_gsi;
        if (gsi < first_gsi) begin
          e.status = irt_pkg::STAT_BELOW;
        end else if (idx >= 32'(lim)) begin
          e.status = irt_pkg::STAT_BEYOND;
        end else begin
          e.status = irt_pkg::STAT_OK;
          e.entry_index = idx[4:0];
          case (r.func)
            irt_pkg::FN_ROUTE: begin
              low = {24'd0, r.vector};
              if (hit >= 0) begin
                if (ovr_mode[hit][1:0] == irt_pkg::FLAG_SET)
                  low[irt_pkg::LOWACT_POS] = 1'b1;
                if (ovr_mode[hit][3:2] == irt_pkg::FLAG_SET)
                  low[irt_pkg::LEVEL_POS] = 1'b1;
              end
              redir_low[idx]  = low;
              redir_dest[idx] = r.apic_id;
            end
            irt_pkg::FN_MASK: redir_low[idx][irt_pkg::MASK_POS] = 1'b1;
            default:          redir_low[idx][irt_pkg::MASK_POS] = 1'b0;
          endcase
          e.entry_low  = redir_low[idx];
          e.entry_dest = redir_dest[idx];
        end
      end
      status_seen[e.status]++;
      items++;
      expected_rsp.push_back(e);
    endfunction

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(input irt_pkg::rsp_t a);
      irt_pkg::rsp_t e;
      results++;
      if (expected_rsp.size() == 0) begin
        $display("%0t: result with no item pending, actual %p", $time, a);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      compare_field("status", 32'(e.status), 32'(a.status));
      compare_field("entry_index", 32'(e.entry_index), 32'(a.entry_index));
      compare_field("entry_low", e.entry_low, a.entry_low);
      compare_field("entry_dest", 32'(e.entry_dest), 32'(a.entry_dest));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  irt_pkg::req_t req = '0;
  logic          done;
  irt_pkg::rsp_t rsp;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  route_scoreboard sb = new();
  int          cycles = 0;
  int          settings = 0;
  logic [7:0]  seq_line = '0;
  int          seq_left = 0;

  interrupt_route_table_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(rsp);
      if (start && !busy) sb.note_request(req);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               sb.expected_rsp.size());
      $display("interrupt_route_table_top_tb NOT OK");
      $finish;
    end
  end

  function automatic irt_pkg::req_t mk(input irt_pkg::func_t fn, input logic [7:0] line,
                                       input logic [7:0] vec, input logic [7:0] dest,
                                       input logic [31:0] gsi, input logic [3:0] flags);
    irt_pkg::req_t r;
    r.func      = fn;
    r.irq       = line;
    r.vector    = vec;
    r.apic_id   = dest;
    r.ovr_gsi   = gsi;
    r.ovr_flags = flags;
    return r;
  endfunction

  function automatic logic [7:0] pick_line();
    if ($urandom_range(0, 19) < 3) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 40));
  endfunction

  function automatic irt_pkg::req_t next_item();
    irt_pkg::req_t r;
    logic [31:0]   gsi;
    int            roll;
    gsi  = ($urandom_range(0, 3) == 0) ? $urandom : sb.first_gsi + $urandom_range(0, 27);
    r    = mk(irt_pkg::FN_ROUTE, pick_line(), 8'($urandom), 8'($urandom), gsi,
              4'($urandom));
    roll = $urandom_range(0, 99);
    if (seq_left > 0) begin
      // mask / unmask on the line just routed
      r.irq  = seq_line;
      r.func = $urandom_range(0, 1) ? irt_pkg::FN_MASK : irt_pkg::FN_UNMASK;
      seq_left--;
    end else if (roll < 3) begin
      r.func = irt_pkg::FN_ADD;
      r.irq  = 8'($urandom_range(0, 31));
    end else if (roll < 13) begin
      r.func = 2'($urandom);
    end else begin
      seq_line = r.irq;
      seq_left = $urandom_range(0, 3);
    end
    return r;
  endfunction

  task automatic drive_item(input irt_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_rsp.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== sb.reg_value(idx)) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, idx,
               sb.reg_value(idx), rd);
      sb.errors++;
    end
  endtask

  task automatic set_config(input logic [31:0] base, input logic [4:0] cnt,
                            input logic en);
    drain();
    cfg_write(irt_pkg::REG_FIRST_GSI, base);
    cfg_write(irt_pkg::REG_REDIR_COUNT, {27'd0, cnt});
    cfg_write(irt_pkg::REG_ENABLED, {31'd0, en});
    settings++;
  endtask

  initial begin
    logic [31:0] phase_base [PHASES];
    logic [4:0]  phase_count [PHASES];
    logic        phase_en [PHASES];
    int          phase_len [PHASES];
    int          left;
    int          burst;

    phase_base  = '{32'd0, 32'($urandom_range(1, 8)), 32'd0, 32'hFFFF_FFFF, 32'd16, 32'd0};
    phase_count = '{5'd24, 5'($urandom_range(1, 24)), 5'd1, 5'd31, 5'd24, 5'd0};
    phase_en    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    phase_len   = '{250, 200, 150, 120, 100, 80};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset; add still works
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd0, 8'h11, 8'h22, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ADD, 8'd0, 8'h00, 8'h00, 32'd2, 4'hF));
    drain();
    cfg_write(irt_pkg::REG_ENABLED, 32'd1);
    drive_item(mk(irt_pkg::FN_UNMASK, 8'd1, 8'h00, 8'h00, 32'hFFFF_FFFF, 4'hF));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'hF));
    drive_item(mk(irt_pkg::FN_MASK, 8'd1, 8'h00, 8'h00, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd0, 8'h00, 8'h00, 32'd0, 4'h0));
    // second override for the same line is shadowed by the first
    drive_item(mk(irt_pkg::FN_ADD, 8'd0, 8'h00, 8'h00, 32'd5, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd0, 8'h5A, 8'hA5, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ADD, 8'd255, 8'h00, 8'h00, 32'hFFFF_FFFF, 4'h3));
    drive_item(mk(irt_pkg::FN_ADD, 8'd3, 8'h00, 8'h00, 32'd23, 4'hC));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd3, 8'h33, 8'h01, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd255, 8'h44, 8'h02, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd24, 8'h55, 8'h03, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd23, 8'h66, 8'h04, 32'd0, 4'h0));
    set_config(32'hFFFF_FFFF, 5'd31, 1'b1);
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd255, 8'h77, 8'h05, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_UNMASK, 8'd255, 8'h00, 8'h00, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd1, 8'h88, 8'h06, 32'd0, 4'h0));
    set_config(32'd0, 5'd0, 1'b1);
    drive_item(mk(irt_pkg::FN_MASK, 8'd1, 8'h00, 8'h00, 32'd0, 4'h0));
    set_config(32'd1, 5'd1, 1'b1);
    drive_item(mk(irt_pkg::FN_UNMASK, 8'd1, 8'h00, 8'h00, 32'd0, 4'h0));
    drive_item(mk(irt_pkg::FN_ROUTE, 8'd2, 8'h99, 8'h07, 32'd0, 4'h0));

    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_base[p], phase_count[p], phase_en[p]);
      seq_left = 0;
      left = phase_len[p];
      while (left > 0) begin
        burst = $urandom_range(1, 10);
        for (int b = 0; b < burst && left > 0; b++) begin
          drive_item(next_item());
          left--;
        end
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items, %0d results, %0d register settings, %0d overrides in use",
             sb.items, sb.results, settings, sb.ovr_used);
    $display("status ok %0d disabled %0d below %0d beyond %0d full %0d",
             sb.status_seen[irt_pkg::STAT_OK], sb.status_seen[irt_pkg::STAT_DISABLED],
             sb.status_seen[irt_pkg::STAT_BELOW], sb.status_seen[irt_pkg::STAT_BEYOND],
             sb.status_seen[irt_pkg::STAT_FULL]);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("interrupt_route_table_top_tb OK");
    end else begin
      $display("interrupt_route_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule
